@@ design/modinv_pkg.sv @@
// shared command and status types for the modular inverse unit
package modinv_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new item, start the reduction division
        logic grow;     // shift the divisor up by one bit
        logic shrink;   // conditional subtract, shift the divisor down
        logic end_red;  // last reduction bit, set up the euclid loop
        logic end_euc;  // last bit of one euclid step, rotate remainders
        logic finish;   // write the result register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic m_zero;
        logic can_grow;
        logic k_zero;
        logic rem_zero;
    } sts_t;

endpackage

@@ design/modinv_if.sv @@
// handshake channels of the modular inverse unit

interface modinv_in_if #(parameter int WIDTH = 32);
    logic               valid;
    logic               ready;
    logic signed [WIDTH:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface modinv_out_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

interface modinv_cfg_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

@@ design/modinv_dp.sv @@
// datapath: shift-subtract divider with bezout coefficient tracking
module modinv_dp #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WIDTH-1:0]   cfg_modulus,
    input  logic [WIDTH:0]     value,
    input  modinv_pkg::cmd_t   cmd,
    output modinv_pkg::sts_t   sts,
    output logic [WIDTH-1:0]   inverse,
    output logic               no_inverse
);

    localparam int AW = WIDTH + 1;
    localparam int SW = WIDTH + 2;
    localparam int KW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] mod_reg;
    logic [AW-1:0]    a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [AW-1:0]    d_reg;
    logic [SW-1:0]    sa_reg;
    logic [SW-1:0]    sb_reg;
    logic [SW-1:0]    sd_reg;
    logic [KW-1:0]    k_reg;
    logic             neg_reg;
    logic [WIDTH-1:0] inv_reg;
    logic             noinv_reg;

    logic [AW-1:0]    mag;
    logic [AW:0]      dbl;
    logic             ge;
    logic [AW-1:0]    a_sub;
    logic [SW-1:0]    sa_sub;
    logic [WIDTH-1:0] rem_w;
    logic [WIDTH-1:0] r_adj;
    logic [WIDTH-1:0] r_red;
    logic             sneg;
    logic [SW-1:0]    smag;
    logic             fin_noinv;
    logic [WIDTH-1:0] fin_inv;

    assign mag   = value[WIDTH] ? (~value + AW'(1)) : value;
    assign dbl   = {d_reg, 1'b0};
    assign ge    = (a_reg >= d_reg);
    assign a_sub = ge ? (a_reg - d_reg) : a_reg;
    assign sa_sub = ge ? (sa_reg - sd_reg) : sa_reg;
    assign rem_w = a_sub[WIDTH-1:0];

    // fold a negative value back into range, then map zero onto m
    assign r_adj = (neg_reg && (rem_w != '0)) ? (mod_reg - rem_w) : rem_w;
    assign r_red = (r_adj == '0) ? mod_reg : r_adj;

    // coefficient magnitude is at most m
    assign sneg = sa_reg[SW-1];
    assign smag = sneg ? (~sa_reg + SW'(1)) : sa_reg;
    assign fin_noinv = (mod_reg == '0) || (a_reg != AW'(1));

    always_comb
    begin
        if (fin_noinv || (smag == '0) || (smag == {2'b00, mod_reg}))
            fin_inv = '0;
        else if (sneg)
            fin_inv = mod_reg - smag[WIDTH-1:0];
        else
            fin_inv = smag[WIDTH-1:0];
    end

    assign sts.m_zero   = (mod_reg == '0);
    assign sts.can_grow = (dbl <= {1'b0, a_reg});
    assign sts.k_zero   = (k_reg == '0);
    assign sts.rem_zero = (a_sub == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= WIDTH'(1);
        else if (cfg_we)
            mod_reg <= cfg_modulus;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= mag;
            d_reg   <= {1'b0, mod_reg};
            k_reg   <= '0;
            neg_reg <= value[WIDTH];
        end
        else if (cmd.grow)
        begin
            d_reg  <= d_reg << 1;
            sd_reg <= sd_reg << 1;
            k_reg  <= k_reg + KW'(1);
        end
        else if (cmd.shrink)
        begin
            a_reg  <= a_sub;
            sa_reg <= sa_sub;
            d_reg  <= d_reg >> 1;
            sd_reg <= SW'($signed(sd_reg) >>> 1);
            k_reg  <= k_reg - KW'(1);
        end
        else if (cmd.end_red)
        begin
            a_reg  <= {1'b0, r_red};
            b_reg  <= mod_reg;
            d_reg  <= {1'b0, mod_reg};
            sa_reg <= SW'(1);
            sb_reg <= '0;
            sd_reg <= '0;
            k_reg  <= '0;
        end
        else if (cmd.end_euc)
        begin
            a_reg  <= {1'b0, b_reg};
            b_reg  <= rem_w;
            d_reg  <= {1'b0, rem_w};
            sa_reg <= sb_reg;
            sb_reg <= sa_sub;
            sd_reg <= sa_sub;
            k_reg  <= '0;
        end

        if (cmd.finish)
        begin
            inv_reg   <= fin_inv;
            noinv_reg <= fin_noinv;
        end
    end

    assign inverse    = inv_reg;
    assign no_inverse = noinv_reg;

endmodule

@@ design/modinv_ctrl.sv @@
// controller: sequences reduction, euclid steps and result hand-off
module modinv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  modinv_pkg::sts_t sts,
    output modinv_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_UP    = 4'b0010,
        ST_DOWN  = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   red_reg, red_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        red_next   = red_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    red_next   = 1'b1;
                    state_next = sts.m_zero ? ST_FINAL : ST_UP;
                end
            end
            ST_UP:
            begin
                if (sts.can_grow)
                    cmd.grow = 1'b1;
                else
                    state_next = ST_DOWN;
            end
            ST_DOWN:
            begin
                if (!sts.k_zero)
                    cmd.shrink = 1'b1;
                else if (red_reg)
                begin
                    cmd.end_red = 1'b1;
                    red_next    = 1'b0;
                    state_next  = ST_UP;
                end
                else
                begin
                    cmd.end_euc = 1'b1;
                    state_next  = sts.rem_zero ? ST_FINAL : ST_UP;
                end
            end
            ST_FINAL:
            begin
                // result register must be empty or draining
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            red_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_reg       <= red_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result written but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && out_valid_reg) |-> out_ready)
        else $error("pending result overwritten");

    a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.m_zero) |=> (state_reg == ST_FINAL))
        else $error("zero modulus did not skip to result");

    a_shrink_stays: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shrink |=> (state_reg == ST_DOWN))
        else $error("left division before last quotient bit");
`endif

endmodule

@@ design/modular_inverse_extgcd_unit.sv @@
// Modular inverse unit by iterative extended Euclid, top level.
// Steps: load, reduction of the value modulo m, then one one-bit shift-subtract division per
// euclid step until the remainder is zero, then the result write; a zero modulus skips straight
// to the result write. A result still waiting at the output holds off the next one.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: controller idle, result register empty, modulus set to 1.
module modular_inverse_extgcd_unit #(
    parameter int WIDTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    modinv_cfg_if.sink   cfg,
    modinv_in_if.sink    req,
    modinv_out_if.source rsp
);

    modinv_pkg::cmd_t cmd;
    modinv_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    modinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    modinv_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_modulus (cfg.modulus[WIDTH-1:0]),
        .value       (req.value[WIDTH:0]),
        .cmd         (cmd),
        .sts         (sts),
        .inverse     (rsp.inverse),
        .no_inverse  (rsp.no_inverse)
    );

endmodule
